// ===== design/mi3_pkg.sv =====
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int DW    = 24;   // matrix and inverse element width
  localparam int PW    = 48;   // element product width
  localparam int AW    = 49;   // adjugate entry width
  localparam int LOW   = 25;   // low split of an adjugate entry for the det multiply
  localparam int DETW  = 76;   // signed determinant width
  localparam int MAGW  = 75;   // determinant magnitude width
  localparam int CW    = 100;  // divider compare width
  localparam int QB    = 24;   // quotient bits produced below the overflow check
  localparam int FRAC2 = 32;   // numerator scale shift
  localparam int THRW  = 23;
  localparam int NE    = 9;
  localparam int FRONT_LAT = 6;
  localparam int LANE_LAT  = QB + 1;
  localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

  localparam logic [THRW-1:0] THR_RESET = 23'd33;
  localparam logic [DW-1:0]   Q_ONE     = 24'h010000;
  localparam logic [DW-1:0]   OUT_MAX   = 24'h7FFFFF;
  localparam logic [DW-1:0]   OUT_MIN   = 24'h800000;

  // adj[k] = m[A]*m[B] - m[C]*m[D]
  localparam int unsigned ADJ_A [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned ADJ_B [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned ADJ_C [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned ADJ_D [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef logic signed [DW-1:0] elem_t;
  typedef logic signed [AW-1:0] adj_t;

  typedef struct packed {
    logic [MAGW-1:0] mag;
    logic            neg;
    logic            sing;
  } det_ctl_t;

  typedef struct packed {
    logic          ovf;
    logic          neg;
    logic [QB-1:0] q;
    logic          sing;
  } lane_res_t;

endpackage

// ===== design/mi3_in_if.sv =====
`timescale 1ns / 1ps
interface mi3_in_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t m11, m12, m13, m21, m22, m23, m31, m32, m33;
  modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                  input ready);
  modport sink (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                output ready);
endinterface

// ===== design/mi3_out_if.sv =====
`timescale 1ns / 1ps
interface mi3_out_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33;
  logic  singular;
  modport source (output valid, inv11, inv12, inv13, inv21, inv22, inv23, inv31,
                  inv32, inv33, singular, input ready);
  modport sink (input valid, inv11, inv12, inv13, inv21, inv22, inv23, inv31,
                inv32, inv33, singular, output ready);
endinterface

// ===== design/mi3_front.sv =====
`timescale 1ns / 1ps
module mi3_front
  import mi3_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  elem_t           m_i [NE],
  input  logic [THRW-1:0] thr,
  output adj_t            adj_o [NE],
  output det_ctl_t        ctl_o
);

  logic signed [PW-1:0]     pp_r [NE];
  logic signed [PW-1:0]     pn_r [NE];
  elem_t                    row1_r1 [3];
  adj_t                     adj_r2 [NE];
  elem_t                    row1_r2 [3];
  logic signed [PW-1:0]     ph_r3 [3];
  logic signed [PW+1:0]     pl_r3 [3];
  adj_t                     adj_r3 [NE];
  logic signed [DETW-1:0]   t_r4 [3];
  adj_t                     adj_r4 [NE];
  logic signed [DETW-1:0]   det_r5;
  adj_t                     adj_r5 [NE];
  adj_t                     adj_r6 [NE];
  det_ctl_t                 ctl_r6;

  logic signed [DETW-1:0]   t_nxt [3];
  logic signed [DETW-1:0]   det_nxt;
  logic [MAGW-1:0]          mag_nxt;
  logic [MAGW-1:0]          lim;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t_nxt[j] = ({{(DETW-PW){ph_r3[j][PW-1]}}, ph_r3[j]} <<< LOW)
               + {{(DETW-PW-2){pl_r3[j][PW+1]}}, pl_r3[j]};
    end
    det_nxt = t_r4[0] + t_r4[1] + t_r4[2];
    mag_nxt = det_r5[DETW-1] ? MAGW'(-det_r5) : MAGW'(det_r5);
    lim     = {{(MAGW-THRW-FRAC2){1'b0}}, thr, {FRAC2{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        pp_r[k]   <= m_i[ADJ_A[k]] * m_i[ADJ_B[k]];
        pn_r[k]   <= m_i[ADJ_C[k]] * m_i[ADJ_D[k]];
        adj_r2[k] <= {pp_r[k][PW-1], pp_r[k]} - {pn_r[k][PW-1], pn_r[k]};
        adj_r3[k] <= adj_r2[k];
        adj_r4[k] <= adj_r3[k];
        adj_r5[k] <= adj_r4[k];
        adj_r6[k] <= adj_r5[k];
      end
      for (int j = 0; j < 3; j++) begin
        row1_r1[j] <= m_i[j];
        row1_r2[j] <= row1_r1[j];
        // split the adjugate entry: signed high part, unsigned low part
        ph_r3[j] <= row1_r2[j] * $signed(adj_r2[3*j][AW-1:LOW]);
        pl_r3[j] <= row1_r2[j] * $signed({1'b0, adj_r2[3*j][LOW-1:0]});
        t_r4[j]  <= t_nxt[j];
      end
      det_r5      <= det_nxt;
      ctl_r6.mag  <= mag_nxt;
      ctl_r6.neg  <= det_r5[DETW-1];
      ctl_r6.sing <= (mag_nxt == '0) || (mag_nxt < lim);
    end
  end

  assign adj_o = adj_r6;
  assign ctl_o = ctl_r6;

endmodule

// ===== design/mi3_lane.sv =====
`timescale 1ns / 1ps
module mi3_lane
  import mi3_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  adj_t      adj_i,
  input  det_ctl_t  ctl_i,
  output lane_res_t res_o
);

  logic [CW-1:0]   rem_r  [QB+1];
  logic [MAGW-1:0] d_r    [QB+1];
  logic [QB-1:0]   q_r    [QB+1];
  logic            ovf_r  [QB+1];
  logic            neg_r  [QB+1];
  logic            sing_r [QB+1];

  logic [AW-1:0] amag;
  logic [CW-1:0] num;
  logic [CW-1:0] dtop;

  always_comb begin
    amag = adj_i[AW-1] ? AW'(-adj_i) : AW'(adj_i);
    num  = {{(CW-AW-FRAC2){1'b0}}, amag, {FRAC2{1'b0}}};
    dtop = {{(CW-MAGW){1'b0}}, ctl_i.mag} << QB;
  end

  // entry stage: a quotient of 2^24 or more is flagged as overflow here
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      d_r[0]    <= ctl_i.mag;
      q_r[0]    <= '0;
      ovf_r[0]  <= num >= dtop;
      neg_r[0]  <= adj_i[AW-1] ^ ctl_i.neg;
      sing_r[0] <= ctl_i.sing;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [CW-1:0] dsh;
    logic [CW:0]   diff;
    assign dsh  = {{(CW-MAGW){1'b0}}, d_r[s-1]} << (QB - s);
    assign diff = {1'b0, rem_r[s-1]} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= diff[CW] ? rem_r[s-1] : diff[CW-1:0];
        q_r[s]    <= {q_r[s-1][QB-2:0], ~diff[CW]};
        d_r[s]    <= d_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        sing_r[s] <= sing_r[s-1];
      end
    end
  end

  assign res_o = '{ovf: ovf_r[QB], neg: neg_r[QB], q: q_r[QB], sing: sing_r[QB]};

endmodule

// ===== design/mi3_merge.sv =====
`timescale 1ns / 1ps
module mi3_merge
  import mi3_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  lane_res_t res_i [NE],
  output elem_t     inv_o [NE],
  output logic      sing_o
);

  logic [DW-1:0] val_nxt [NE];
  logic [DW-1:0] inv_r   [NE];
  logic          sing_r;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (res_i[0].sing) begin
        val_nxt[k] = (k % 4 == 0) ? Q_ONE : '0;
      end else if (res_i[k].ovf) begin
        val_nxt[k] = res_i[k].neg ? OUT_MIN : OUT_MAX;
      end else if (res_i[k].neg) begin
        val_nxt[k] = (res_i[k].q > OUT_MIN) ? OUT_MIN : DW'(-res_i[k].q);
      end else begin
        val_nxt[k] = (res_i[k].q > OUT_MAX) ? OUT_MAX : res_i[k].q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_r  <= val_nxt;
      sing_r <= res_i[0].sing;
    end
  end

  always_comb begin
    for (int k = 0; k < NE; k++) inv_o[k] = $signed(inv_r[k]);
  end
  assign sing_o = sing_r;

endmodule

// ===== design/matrix3_inverse.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// in_bus    in   valid/ready    m11..m33, signed Q8.16
// out_bus   out  valid/ready    inv11..inv33 signed Q8.16, singular
// cfg_      in   cfg_we         cfg_wdata = singular_threshold
//
// One matrix per cycle while the output is not stalled; each passes through the
// cofactor and determinant stages, the nine pipelined restoring divider lanes
// (one quotient bit per stage), then the merge/output register.
// rst_n clears the valid chain and sets the threshold to 33.
// A stalled output beat freezes the whole pipeline; in_bus.ready follows.
module matrix3_inverse
  import mi3_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  mi3_in_if.sink          in_bus,
  mi3_out_if.source       out_bus,
  input  logic            cfg_we,
  input  logic [THRW-1:0] cfg_wdata
);

  logic [THRW-1:0]      thr_r;
  logic [TOTAL_LAT-1:0] vld_r;
  logic                 en;
  elem_t                m [NE];
  adj_t                 adj [NE];
  det_ctl_t             ctl;
  lane_res_t            res [NE];
  elem_t                inv [NE];
  logic                 sing;

  assign en           = ~vld_r[TOTAL_LAT-1] | out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[TOTAL_LAT-2:0], in_bus.valid};
    end
  end

  assign m = '{in_bus.m11, in_bus.m12, in_bus.m13, in_bus.m21, in_bus.m22,
               in_bus.m23, in_bus.m31, in_bus.m32, in_bus.m33};

  mi3_front u_front (
    .clk   (clk),
    .en    (en),
    .m_i   (m),
    .thr   (thr_r),
    .adj_o (adj),
    .ctl_o (ctl)
  );

  for (genvar k = 0; k < NE; k++) begin : g_lane
    mi3_lane u_lane (
      .clk   (clk),
      .en    (en),
      .adj_i (adj[k]),
      .ctl_i (ctl),
      .res_o (res[k])
    );
  end

  mi3_merge u_merge (
    .clk    (clk),
    .en     (en),
    .res_i  (res),
    .inv_o  (inv),
    .sing_o (sing)
  );

  assign out_bus.valid    = vld_r[TOTAL_LAT-1];
  assign out_bus.inv11    = inv[0];
  assign out_bus.inv12    = inv[1];
  assign out_bus.inv13    = inv[2];
  assign out_bus.inv21    = inv[3];
  assign out_bus.inv22    = inv[4];
  assign out_bus.inv23    = inv[5];
  assign out_bus.inv31    = inv[6];
  assign out_bus.inv32    = inv[7];
  assign out_bus.inv33    = inv[8];
  assign out_bus.singular = sing;

endmodule
